// File: src/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the partition fit allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PIDX_W     = 5;  // width of partition index fields
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;  // widest register

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;

    // fit policies, the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd2;

    // classified request passed from front to back
    typedef struct packed {
        logic              is_alloc;
        logic [PIDX_W-1:0] index;
        logic              last;
    } cmd_t;

endpackage

// File: src/pfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_front
// request intake: classifies requests and queues them for the back end
// ----------------------------------------------------------------------------
module pfa_front #(
    parameter int MAX_PARTITIONS = 32,
    parameter int SIZE_BITS      = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [pfa_pkg::PIDX_W-1:0] s_part_index,
    input  logic [SIZE_BITS-1:0]      s_size_value,
    input  logic                      s_last_request,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output pfa_pkg::cmd_t             cmd,
    output logic [SIZE_BITS-1:0]      cmd_size
);
    import pfa_pkg::*;

    localparam int DEPTH = 2;

    cmd_t                 q_cmd_reg  [DEPTH];
    logic [SIZE_BITS-1:0] q_size_reg [DEPTH];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           fill_reg, fill_next;
    logic                 in_range;
    logic                 keep;
    logic                 push;
    logic                 pop;
    cmd_t                 in_cmd;

    // loads beyond the table are taken and dropped
    assign in_range = (32'(s_part_index) < MAX_PARTITIONS);
    assign keep     = s_req_type | in_range;

    always_comb begin
        in_cmd.is_alloc = s_req_type;
        in_cmd.index    = s_part_index;
        in_cmd.last     = s_req_type & s_last_request;  // flag ignored on loads
    end

    assign s_ready   = (fill_reg != 2'(DEPTH));
    assign cmd_valid = (fill_reg != 2'd0);
    assign push      = s_valid & s_ready & keep;
    assign pop       = cmd_valid & cmd_ready;
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_size  = q_size_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_cmd_reg[wr_ptr_reg]  <= in_cmd;
            q_size_reg[wr_ptr_reg] <= s_size_value;
        end
    end

endmodule

// File: src/pfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_back
// execution engine: size table, fit scan and result register
// ----------------------------------------------------------------------------
module pfa_back #(
    parameter int MAX_PARTITIONS = 32,
    parameter int SIZE_BITS      = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  pfa_pkg::cmd_t                cmd,
    input  logic [SIZE_BITS-1:0]         cmd_size,
    input  logic [pfa_pkg::POLICY_W-1:0] fit_policy,
    input  logic [pfa_pkg::COUNT_W-1:0]  part_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_granted,
    output logic [pfa_pkg::PIDX_W-1:0]   m_alloc_index,
    output logic [SIZE_BITS-1:0]         m_alloc_size
);
    import pfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SIZE_BITS-1:0]    mem [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0]    rd_data_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]        eff_count;
    logic [MAX_PARTITIONS-1:0] used_reg, used_next;
    logic [SIZE_BITS-1:0]    req_size_reg, req_size_next;
    logic                    last_reg, last_next;
    logic                    have_reg, have_next;
    logic [IDX_W-1:0]        pick_reg, pick_next;
    logic [SIZE_BITS-1:0]    best_reg, best_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_granted_reg;
    logic [PIDX_W-1:0]       out_index_reg;
    logic [SIZE_BITS-1:0]    out_size_reg;
    logic [SIZE_BITS-1:0]    cur_free;
    logic                    fits;
    logic                    take;
    logic                    grant;
    logic                    out_free;
    logic                    finish;
    logic                    mem_we;
    logic [31:0]             load_ext;
    logic [31:0]             pick_ext;

    assign eff_count = (32'(part_count) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                          : CNT_W'(part_count);
    assign load_ext  = 32'(cmd.index);
    assign pick_ext  = 32'(pick_reg);

    // a granted entry reads as zero until restored or reloaded
    assign cur_free = used_reg[rd_idx_reg] ? '0 : rd_data_reg;
    assign fits     = (cur_free >= req_size_reg);

    always_comb begin
        case (fit_policy)
            POLICY_WORST: take = !have_reg || (cur_free > best_reg);
            POLICY_BEST:  take = fits && (!have_reg || (cur_free < best_reg));
            default:      take = fits && !have_reg;
        endcase
    end

    assign grant     = have_reg && (best_reg >= req_size_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign finish    = (state_reg == ST_FINISH) && out_free;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign mem_we    = cmd_valid && cmd_ready && !cmd.is_alloc;

    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        used_next      = used_reg;
        req_size_next  = req_size_reg;
        last_next      = last_reg;
        have_next      = have_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (rd_pend_reg && take) begin
            have_next = 1'b1;
            pick_next = rd_idx_reg;
            best_next = cur_free;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (!cmd.is_alloc) begin
                        used_next[load_ext[IDX_W-1:0]] = 1'b0;
                    end else begin
                        req_size_next = cmd_size;
                        last_next     = cmd.last;
                        have_next     = 1'b0;
                        pick_next     = '0;
                        best_next     = '0;
                        scan_cnt_next = '0;
                        state_next    = (eff_count == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == eff_count - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (grant) begin
                        used_next[pick_reg] = 1'b1;
                    end
                    if (last_reg) begin
                        used_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rd_pend_reg   <= (state_reg == ST_SCAN);
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        req_size_reg <= req_size_next;
        last_reg     <= last_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        if (state_reg == ST_SCAN) begin
            rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
        if (finish) begin
            out_granted_reg <= grant;
            out_index_reg   <= grant ? pick_ext[PIDX_W-1:0] : '0;
            out_size_reg    <= grant ? best_reg : '0;
        end
    end

    // size table, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[load_ext[IDX_W-1:0]] <= cmd_size;
        end
        if (state_reg == ST_SCAN) begin
            rd_data_reg <= mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_granted     = out_granted_reg;
    assign m_alloc_index = out_index_reg;
    assign m_alloc_size  = out_size_reg;

endmodule

// File: src/partition_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_fit_allocator
// fixed-partition allocator with first, best and worst fit policies
// ----------------------------------------------------------------------------
// A load request writes one partition size and gives no result; the back
// end takes it while idle and stays idle. An allocate request scans the
// first partition_count partitions (clamped to MAX_PARTITIONS), one table
// read per cycle from the single read port, in states ST_IDLE (start),
// ST_SCAN (one step per partition read), ST_DRAIN (last compare) and
// ST_FINISH (result written). With a count of zero there is no scan and the
// request goes from ST_IDLE straight to ST_FINISH. Writing the result also
// waits while an earlier result is still held unaccepted. A two-entry
// request queue sits between intake and back end, and a result register
// holds a finished result while the next request is taken. Granted
// partitions are tracked by one flag each (cleared at reset), so a restore
// on last_request clears them all as the result is written. Sizes of
// partitions that were never loaded are undefined. Write fit_policy and
// partition_count only while the block is idle.
module partition_fit_allocator #(
    parameter int MAX_PARTITIONS = 32,
    parameter int SIZE_BITS      = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [pfa_pkg::PIDX_W-1:0]     s_part_index,
    input  logic [SIZE_BITS-1:0]           s_size_value,
    input  logic                           s_last_request,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_granted,
    output logic [pfa_pkg::PIDX_W-1:0]     m_alloc_index,
    output logic [SIZE_BITS-1:0]           m_alloc_size
);
    import pfa_pkg::*;

    logic [POLICY_W-1:0]  fit_policy_reg;
    logic [COUNT_W-1:0]   part_count_reg;
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_t                 cmd;
    logic [SIZE_BITS-1:0] cmd_size;

    // configuration registers, written straight from the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= POLICY_FIRST;
            part_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIT_POLICY: fit_policy_reg <= cfg_wdata[POLICY_W-1:0];
                REG_PART_COUNT: part_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // intake: classification and request queue
    pfa_front #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_part_index   (s_part_index),
        .s_size_value   (s_size_value),
        .s_last_request (s_last_request),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .cmd_size       (cmd_size)
    );

    // back end: size table, scan and result register
    pfa_back #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cmd_size      (cmd_size),
        .fit_policy    (fit_policy_reg),
        .part_count    (part_count_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_alloc_index (m_alloc_index),
        .m_alloc_size  (m_alloc_size)
    );

endmodule

// File: src/pfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks of the partition fit allocator
// ----------------------------------------------------------------------------
module pfa_checker #(
    parameter int SIZE_BITS = 16
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_granted,
    input logic [pfa_pkg::PIDX_W-1:0] m_alloc_index,
    input logic [SIZE_BITS-1:0]       m_alloc_size
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted)
            && $stable(m_alloc_index) && $stable(m_alloc_size))
        else $error("result changed while stalled");

    // refused request reports zero index and size
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> (m_alloc_index == '0) && (m_alloc_size == '0))
        else $error("refused result carries nonzero fields");

    // reset empties the queue and the result register
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind partition_fit_allocator pfa_checker #(
    .SIZE_BITS (SIZE_BITS)
) u_pfa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_granted     (m_granted),
    .m_alloc_index (m_alloc_index),
    .m_alloc_size  (m_alloc_size)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the partition fit allocator
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a driver that works on the falling edge.
// A monitor on the rising edge keeps its own copy of the partition tables and
// the fit registers, and works out the grant that each accepted allocate
// should produce. Each result is checked against the oldest expected grant.
// A short directed run covers count zero, the zero-size request, ties, the
// unused policy code and the last flag. Random phases then follow, each with
// its own policy, partition count and handshake idling.
// ----------------------------------------------------------------------------
module tb;
    import pfa_pkg::*;

    localparam int NPART         = 32;
    localparam int SIZE_W        = 16;
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES = 80;    // covers a full scan plus the request queue
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 225;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;
    // the fourth policy code is unused and should act as first fit
    localparam logic [POLICY_W-1:0] POLICY_UNUSED = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [PIDX_W-1:0] part_index;
        logic [SIZE_W-1:0] size_value;
        logic              last_request;
    } alloc_req_t;

    typedef struct packed {
        logic              granted;
        logic [PIDX_W-1:0] alloc_index;
        logic [SIZE_W-1:0] alloc_size;
    } grant_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [PIDX_W-1:0]     s_part_index;
    logic [SIZE_W-1:0]     s_size_value;
    logic                  s_last_request;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_granted;
    logic [PIDX_W-1:0]     m_alloc_index;
    logic [SIZE_W-1:0]     m_alloc_size;

    // shadow of the block state
    logic [SIZE_W-1:0]   orig_sz [NPART];
    logic [SIZE_W-1:0]   free_sz [NPART];
    logic [POLICY_W-1:0] cur_policy;
    logic [COUNT_W-1:0]  cur_count;

    alloc_req_t pending_reqs[$];
    grant_t     expected_grants[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int errors;
    int stall_cycles;
    bit s_taken;  // set by the monitor when the request on the port was accepted

    partition_fit_allocator #(
        .MAX_PARTITIONS(NPART),
        .SIZE_BITS     (SIZE_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_part_index  (s_part_index),
        .s_size_value  (s_size_value),
        .s_last_request(s_last_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_alloc_index (m_alloc_index),
        .m_alloc_size  (m_alloc_size)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // load writes one slot; allocate searches the tables and clears the winner
    function automatic void predict_allocation(alloc_req_t r);
        int                lim;
        int                pick;
        bit                found;
        logic [SIZE_W-1:0] top;
        grant_t            g;
        if (r.req_type == REQ_LOAD) begin
            // last flag has no meaning on a load
            orig_sz[r.part_index] = r.size_value;
            free_sz[r.part_index] = r.size_value;
            return;
        end
        lim   = (cur_count > NPART) ? NPART : int'(cur_count);
        pick  = 0;
        found = 1'b0;
        if (cur_policy == POLICY_WORST) begin
            // first maximum wins, then granted only if it covers the request
            if (lim > 0) begin
                top = free_sz[0];
                for (int j = 1; j < lim; j++) begin
                    if (free_sz[j] > top) begin
                        top  = free_sz[j];
                        pick = j;
                    end
                end
                found = (top >= r.size_value);
            end
        end else if (cur_policy == POLICY_BEST) begin
            // strict less-than keeps the lowest index on a tie
            for (int j = 0; j < lim; j++) begin
                if (free_sz[j] >= r.size_value
                        && (!found || free_sz[j] < free_sz[pick])) begin
                    pick  = j;
                    found = 1'b1;
                end
            end
        end else begin
            for (int j = 0; j < lim; j++) begin
                if (!found && free_sz[j] >= r.size_value) begin
                    pick  = j;
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            g.granted     = 1'b1;
            g.alloc_index = pick[PIDX_W-1:0];
            g.alloc_size  = free_sz[pick];
            free_sz[pick] = '0;
        end else begin
            g = '0;
        end
        if (r.last_request) begin
            free_sz = orig_sz;
        end
        expected_grants.push_back(g);
    endfunction

    // driver: a new request goes out only once the previous one was taken
    always @(negedge aclk) begin : drive_proc
        alloc_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
            if (!s_valid || s_taken) begin
                s_taken = 1'b0;
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_req_type     <= nxt.req_type;
                    s_part_index   <= nxt.part_index;
                    s_size_value   <= nxt.size_value;
                    s_last_request <= nxt.last_request;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: results are checked before the request of the same edge is predicted
    always @(posedge aclk) begin : check_proc
        grant_t     want;
        alloc_req_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    note_error($sformatf(
                        "result with nothing expected: granted=%0d index=%0d size=%0d",
                        m_granted, m_alloc_index, m_alloc_size));
                end else begin
                    want = expected_grants.pop_front();
                    if (m_granted !== want.granted || m_alloc_index !== want.alloc_index
                            || m_alloc_size !== want.alloc_size) begin
                        note_error($sformatf({"mismatch: expected granted=%0d index=%0d ",
                            "size=%0d, got granted=%0d index=%0d size=%0d"},
                            want.granted, want.alloc_index, want.alloc_size,
                            m_granted, m_alloc_index, m_alloc_size));
                    end
                end
            end
            if (s_valid && s_ready) begin
                seen.req_type     = s_req_type;
                seen.part_index   = s_part_index;
                seen.size_value   = s_size_value;
                seen.last_request = s_last_request;
                predict_allocation(seen);
                s_taken = 1'b1;
            end
            // watchdog on handshakes of either channel
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    function automatic void push_req(logic kind, int idx, int size, bit last);
        alloc_req_t r;
        r.req_type     = kind;
        r.part_index   = idx[PIDX_W-1:0];
        r.size_value   = size[SIZE_W-1:0];
        r.last_request = last;
        pending_reqs.push_back(r);
    endfunction

    // mostly small sizes so that fits and misses both happen, with the extremes mixed in
    function automatic int rand_size();
        case ($urandom_range(7, 0))
            0:       return 0;
            1:       return 16'hFFFF;
            2, 3:    return $urandom_range(16'hFFFF, 0);
            default: return $urandom_range(600, 0);
        endcase
    endfunction

    // block is idle once every request went out and every result came back,
    // plus time for a trailing load to leave the back end; sampled on the
    // rising edge, where the driver's queue and valid are settled
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DATA_W-1:0];
        if (idx == REG_FIT_POLICY) begin
            cur_policy = data[POLICY_W-1:0];
        end else begin
            cur_count = data[COUNT_W-1:0];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stim_proc
        logic [POLICY_W-1:0] phase_policy [RAND_PHASES];
        int                  phase_count  [RAND_PHASES];
        int                  cnt;
        phase_policy = '{POLICY_FIRST, POLICY_WORST, POLICY_BEST, POLICY_UNUSED,
                         POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_FIRST};
        // a count above 32 should saturate, a negative entry picks one at random
        phase_count  = '{32, 63, 32, 33, 1, 5, 0, -1};

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_req_type     = REQ_LOAD;
        s_part_index   = '0;
        s_size_value   = '0;
        s_last_request = 1'b0;
        m_ready        = 1'b0;
        s_taken        = 1'b0;
        errors         = 0;
        stall_cycles   = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        cur_policy     = POLICY_FIRST;
        cur_count      = '0;
        foreach (orig_sz[j]) begin
            orig_sz[j] = '0;
            free_sz[j] = '0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // count is zero out of reset: nothing is searched, nothing granted
        push_req(REQ_ALLOC, 0, 5, 1'b0);
        wait_idle();
        write_reg(REG_PART_COUNT, 4);
        push_req(REQ_LOAD, 0, 100, 1'b0);
        push_req(REQ_LOAD, 1, 40, 1'b0);
        push_req(REQ_LOAD, 2, 16'hFFFF, 1'b0);
        push_req(REQ_LOAD, 3, 40, 1'b1);       // last flag on a load is ignored
        push_req(REQ_LOAD, 31, 16'hFFFF, 1'b0); // top slot, outside the searched range
        // first fit, then a zero request on an emptied slot, then restore
        push_req(REQ_ALLOC, 0, 50, 1'b0);
        push_req(REQ_ALLOC, 0, 0, 1'b0);
        push_req(REQ_ALLOC, 0, 16'hFFFF, 1'b1);
        wait_idle();
        write_reg(REG_FIT_POLICY, POLICY_WORST);
        push_req(REQ_ALLOC, 0, 10, 1'b0);
        push_req(REQ_ALLOC, 0, 200, 1'b0);
        push_req(REQ_ALLOC, 0, 101, 1'b1);      // largest left is slot 0 at 100: refused
        wait_idle();
        write_reg(REG_FIT_POLICY, POLICY_BEST);
        push_req(REQ_ALLOC, 0, 30, 1'b0);       // tie between slots 1 and 3
        push_req(REQ_ALLOC, 0, 30, 1'b0);
        push_req(REQ_ALLOC, 0, 16'hFFFF, 1'b1);
        wait_idle();
        write_reg(REG_FIT_POLICY, POLICY_UNUSED);
        push_req(REQ_ALLOC, 0, 41, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            write_reg(REG_FIT_POLICY,
                (p == RAND_PHASES - 1) ? $urandom_range(3, 0) : int'(phase_policy[p]));
            cnt = (phase_count[p] < 0) ? $urandom_range(63, 0) : phase_count[p];
            write_reg(REG_PART_COUNT, cnt);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            // every slot is loaded before any wide search can read it
            if (p == 0) begin
                for (int j = 0; j < NPART; j++) begin
                    push_req(REQ_LOAD, j, rand_size(), 1'($urandom_range(1, 0)));
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99, 0) < 15) begin
                    push_req(REQ_LOAD, $urandom_range(NPART - 1, 0), rand_size(),
                        1'($urandom_range(1, 0)));
                end else begin
                    push_req(REQ_ALLOC, $urandom_range(NPART - 1, 0), rand_size(),
                        $urandom_range(5, 0) == 0);
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
src/pfa_pkg.sv
src/pfa_front.sv
src/pfa_back.sv
src/partition_fit_allocator.sv
src/pfa_checker.sv
tb/tb.sv
